/* hdl/trr_pkg.sv */
package trr_pkg;

    // Request codes
    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    // Send codes
    localparam logic [1:0] SEND_NONE  = 2'd0;
    localparam logic [1:0] SEND_ACK   = 2'd1;
    localparam logic [1:0] SEND_ERROR = 2'd2;

    // Error codes (TFTP codes 5, 4, 3)
    localparam logic [1:0] ERR_UNKNOWN_TID = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL_OP  = 2'd1;
    localparam logic [1:0] ERR_DISK_FULL   = 2'd2;

    // Completion codes
    localparam logic [1:0] DONE_NONE    = 2'd0;
    localparam logic [1:0] DONE_OK      = 2'd1;
    localparam logic [1:0] DONE_FAIL    = 2'd2;
    localparam logic [1:0] DONE_TIMEOUT = 2'd3;

    // Protocol constants
    localparam logic [15:0] OP_DATA         = 16'd3;
    localparam logic [15:0] OP_ERROR        = 16'd5;
    localparam logic [15:0] WELL_KNOWN_PORT = 16'd69;
    localparam logic [15:0] BLOCK_BYTES     = 16'd512;

    // Register file
    localparam int          ADDR_W          = 3;
    localparam logic        REG_SERVER_ADDR = 1'b0;   // byte address 0
    localparam logic        REG_TIMEOUT     = 1'b1;   // byte address 4
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

endpackage

/* hdl/trr_if.sv */
interface trr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] opcode;
    logic [15:0] block_number;
    logic [15:0] payload_length;
    logic        write_accepted;

    modport source (
        output valid, req_type, src_addr, src_port, opcode, block_number,
               payload_length, write_accepted,
        input  ready
    );
    modport sink (
        input  valid, req_type, src_addr, src_port, opcode, block_number,
               payload_length, write_accepted,
        output ready
    );
endinterface

interface trr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  send_kind;
    logic [15:0] send_block;
    logic [1:0]  error_kind;
    logic [1:0]  done_kind;
    logic [31:0] file_length;

    modport source (
        output valid, send_kind, send_block, error_kind, done_kind, file_length,
        input  ready
    );
    modport sink (
        input  valid, send_kind, send_block, error_kind, done_kind, file_length,
        output ready
    );
endinterface

/* hdl/tftp_read_receiver.sv */
// Channel  | Dir | Transaction                      | Payload
// ---------+-----+----------------------------------+---------------------------------------
// req      | in  | start, packet header, timer tick | req_type, src_addr, src_port, opcode,
//          |     |                                  | block_number, payload_length,
//          |     |                                  | write_accepted
// res      | out | one result per request           | send_kind, send_block, error_kind,
//          |     |                                  | done_kind, file_length
// APB      | in  | register write / read            | server_addr @0, timeout_ticks @4
//
// One transaction per cycle sustained while res is not stalled. An input
// register feeds the decision logic (peer compare, block compare, one 32-bit
// saturating add), which feeds the result register that also updates the state.
// Reset (rst_n, async, active low) clears the transfer state, both valid
// flags and sets timeout_ticks to 1000. A stall on res holds the result
// register; req stays ready as long as the input stage can move on.
module tftp_read_receiver (
    input  logic                      clk,
    input  logic                      rst_n,
    trr_req_if.sink                   req,
    trr_res_if.source                 res,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [trr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import trr_pkg::*;

    // Configuration registers
    logic [31:0] server_addr_reg;
    logic [15:0] timeout_ticks_reg;

    // Input stage
    logic        in_valid_reg;
    logic [1:0]  in_type_reg;
    logic [31:0] in_addr_reg;
    logic [15:0] in_port_reg;
    logic [15:0] in_opcode_reg;
    logic [15:0] in_block_reg;
    logic [15:0] in_len_reg;
    logic        in_accepted_reg;

    // Transfer state
    logic        active_reg,         active_next;
    logic [15:0] expected_block_reg, expected_block_next;
    logic [31:0] byte_total_reg,     byte_total_next;
    logic        timer_armed_reg,    timer_armed_next;
    logic [15:0] timer_count_reg,    timer_count_next;

    // Result stage
    logic        res_valid_reg;
    logic [1:0]  send_kind_reg,   send_kind_next;
    logic [15:0] send_block_reg,  send_block_next;
    logic [1:0]  error_kind_reg,  error_kind_next;
    logic [1:0]  done_kind_reg,   done_kind_next;
    logic [31:0] file_length_reg, file_length_next;

    logic        stage_load;
    logic        fire;
    logic        peer_ok;
    logic [15:0] tick_count;
    logic [32:0] len_sum;
    logic [31:0] total_sat;
    logic        cfg_write;

    // ---------------------------------------------------------------
    // APB register port: access phase without wait states
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[ADDR_W-1] == REG_TIMEOUT) ? {16'd0, timeout_ticks_reg}
                                                        : server_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_addr_reg   <= '0;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            // Low address bits select byte lanes only; ignore them
            if (paddr[ADDR_W-1] == REG_TIMEOUT)
                timeout_ticks_reg <= pwdata[15:0];
            else
                server_addr_reg <= pwdata;
        end
    end

    // ---------------------------------------------------------------
    // Flow control: the result register loads when empty or drained,
    // the input register refills whenever its content moves on.
    // ---------------------------------------------------------------
    assign stage_load = !res_valid_reg || res.ready;
    assign req.ready  = !in_valid_reg || stage_load;
    assign fire       = in_valid_reg && stage_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg     <= req.req_type;
            in_addr_reg     <= req.src_addr;
            in_port_reg     <= req.src_port;
            in_opcode_reg   <= req.opcode;
            in_block_reg    <= req.block_number;
            in_len_reg      <= req.payload_length;
            in_accepted_reg <= req.write_accepted;
        end
    end

    // ---------------------------------------------------------------
    // Decision logic
    // ---------------------------------------------------------------
    assign peer_ok    = (in_port_reg == WELL_KNOWN_PORT) && (in_addr_reg == server_addr_reg);
    assign tick_count = timer_count_reg + 16'd1;
    assign len_sum    = {1'b0, byte_total_reg} + {17'd0, in_len_reg};
    // Saturate the byte total on carry out
    assign total_sat  = len_sum[32] ? '1 : len_sum[31:0];

    always_comb
    begin
        active_next         = active_reg;
        expected_block_next = expected_block_reg;
        byte_total_next     = byte_total_reg;
        timer_armed_next    = timer_armed_reg;
        timer_count_next    = timer_count_reg;
        send_kind_next      = SEND_NONE;
        send_block_next     = '0;
        error_kind_next     = ERR_UNKNOWN_TID;
        done_kind_next      = DONE_NONE;
        file_length_next    = '0;

        unique case (in_type_reg)
            REQ_START:
            begin
                // Start or restart the transfer
                active_next         = 1'b1;
                expected_block_next = 16'd1;
                byte_total_next     = '0;
                timer_armed_next    = 1'b1;
                timer_count_next    = '0;
            end
            REQ_TICK:
            begin
                if (active_reg && timer_armed_reg)
                begin
                    timer_count_next = tick_count;
                    // Report the timeout once, keep the transfer open
                    if (tick_count >= timeout_ticks_reg)
                    begin
                        done_kind_next   = DONE_TIMEOUT;
                        timer_armed_next = 1'b0;
                        timer_count_next = '0;
                    end
                end
            end
            REQ_PACKET:
            begin
                if (active_reg)
                begin
                    if (!peer_ok)
                    begin
                        // Foreign peer: answer with an error, leave the timer running
                        send_kind_next  = SEND_ERROR;
                        error_kind_next = ERR_UNKNOWN_TID;
                    end
                    else
                    begin
                        timer_armed_next = 1'b0;
                        timer_count_next = '0;
                        if (in_opcode_reg == OP_DATA)
                        begin
                            if (in_block_reg < expected_block_reg)
                            begin
                                // Duplicate block: re-ack and re-arm
                                send_kind_next   = SEND_ACK;
                                send_block_next  = in_block_reg;
                                timer_armed_next = 1'b1;
                            end
                            else if (in_block_reg > expected_block_reg || !in_accepted_reg)
                            begin
                                // Block ahead or storage refusal: error and close
                                send_kind_next      = SEND_ERROR;
                                error_kind_next     = (in_block_reg > expected_block_reg)
                                                      ? ERR_ILLEGAL_OP : ERR_DISK_FULL;
                                done_kind_next      = DONE_FAIL;
                                active_next         = 1'b0;
                                expected_block_next = '0;
                                byte_total_next     = '0;
                            end
                            else
                            begin
                                send_kind_next      = SEND_ACK;
                                send_block_next     = in_block_reg;
                                expected_block_next = expected_block_reg + 16'd1;
                                byte_total_next     = total_sat;
                                timer_armed_next    = 1'b1;
                                // Short block ends the transfer
                                if (in_len_reg < BLOCK_BYTES)
                                begin
                                    done_kind_next      = DONE_OK;
                                    file_length_next    = total_sat;
                                    active_next         = 1'b0;
                                    expected_block_next = '0;
                                    byte_total_next     = '0;
                                    timer_armed_next    = 1'b0;
                                end
                            end
                        end
                        else if (in_opcode_reg == OP_ERROR)
                        begin
                            // Server aborted: close as failed
                            done_kind_next      = DONE_FAIL;
                            active_next         = 1'b0;
                            expected_block_next = '0;
                            byte_total_next     = '0;
                        end
                    end
                end
            end
            default:
            begin
                // Unused request code: empty result, no change
            end
        endcase
    end

    // ---------------------------------------------------------------
    // State and result registers advance together on fire
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg         <= 1'b0;
            expected_block_reg <= '0;
            byte_total_reg     <= '0;
            timer_armed_reg    <= 1'b0;
            timer_count_reg    <= '0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            if (stage_load)
                res_valid_reg <= in_valid_reg;
            if (fire)
            begin
                active_reg         <= active_next;
                expected_block_reg <= expected_block_next;
                byte_total_reg     <= byte_total_next;
                timer_armed_reg    <= timer_armed_next;
                timer_count_reg    <= timer_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            send_kind_reg   <= send_kind_next;
            send_block_reg  <= send_block_next;
            error_kind_reg  <= error_kind_next;
            done_kind_reg   <= done_kind_next;
            file_length_reg <= file_length_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.send_kind   = send_kind_reg;
    assign res.send_block  = send_block_reg;
    assign res.error_kind  = error_kind_reg;
    assign res.done_kind   = done_kind_reg;
    assign res.file_length = file_length_reg;

endmodule

/* hdl/trr_checker.sv */
module trr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  send_kind,
    input logic [15:0] send_block,
    input logic [1:0]  error_kind,
    input logic [1:0]  done_kind,
    input logic [31:0] file_length
);
    import trr_pkg::*;

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(send_kind) && $stable(send_block)
                                    && $stable(done_kind) && $stable(file_length))
        else $error("result changed while stalled");

    // A successful close always acknowledges the last block
    a_ok_acks: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_kind == DONE_OK |-> send_kind == SEND_ACK)
        else $error("finished ok without an ACK");

    // An ACK never comes with a failure or a timeout
    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && send_kind == SEND_ACK |-> done_kind == DONE_OK || done_kind == DONE_NONE)
        else $error("ACK paired with failure or timeout");

    // Unused fields stay zero
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (send_kind == SEND_ERROR || error_kind == ERR_UNKNOWN_TID)
                      && (send_kind == SEND_ACK || send_block == 16'd0)
                      && (done_kind == DONE_OK || file_length == 32'd0))
        else $error("unused result field not zero");

endmodule

bind tftp_read_receiver trr_checker u_trr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .send_kind   (res.send_kind),
    .send_block  (res.send_block),
    .error_kind  (res.error_kind),
    .done_kind   (res.done_kind),
    .file_length (res.file_length)
);
